>>> design/cfar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CA-CFAR detector package
// Shared constants, register codes and the structs that pass between the
// raster tracker, the window and the top level.
// ----------------------------------------------------------------------------
package cfar_pkg;

  localparam int MAX_WIDTH_DEF = 1024;  // default line store depth
  localparam int BORDER        = 8;     // border around the frame
  localparam int MIN_DIM       = 17;    // smallest usable width and height
  localparam int WIN_LAG       = 3;     // centre lags the newest pixel by this

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int OUT_COL_W  = 10;
  localparam int CFG_WID_W  = 11;
  localparam int CFG_HGT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STORE_ROWS = 6;
  localparam int COL_DATA_W = STORE_ROWS * PIX_W;

  localparam int FULL_W  = 11;  // seven cells of one column
  localparam int OUTER_W = 10;  // four outer cells of one column
  localparam int SUM_W   = 14;  // forty training cells, or 40 times a pixel

  localparam logic [CFG_WID_W-1:0] WIDTH_RST  = CFG_WID_W'(640);
  localparam logic [CFG_HGT_W-1:0] HEIGHT_RST = CFG_HGT_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Position of the centre pixel decided by one input transaction.
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 emit;
    logic                 inb;
  } cfar_pos_t;

  // Partial training sums and centre pixel leaving the window.
  typedef struct packed {
    logic [PIX_W-1:0]  center;
    logic [SUM_W-1:0]  part_a;
    logic [FULL_W-1:0] full_new;
  } cfar_sums_t;

endpackage

>>> design/cfar_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CA-CFAR raster tracker
// Holds the size registers and the raster counters, and works out the line
// store column and the centre position of each accepted pixel.
// ----------------------------------------------------------------------------
module cfar_raster #(
  parameter int MAX_WIDTH = cfar_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr,
  input  logic [cfar_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfar_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                accept,
  input  logic                                frame_start,
  output logic [$clog2(MAX_WIDTH)-1:0]        rd_col,
  output cfar_pkg::cfar_pos_t                 pos
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WCW   = (COL_W + 1 > cfar_pkg::CFG_WID_W) ? COL_W + 1 : cfar_pkg::CFG_WID_W;
  localparam int WCX   = WCW + 1;
  localparam int RW    = cfar_pkg::ROW_W;

  logic [cfar_pkg::CFG_WID_W-1:0] width_r;
  logic [cfar_pkg::CFG_HGT_W-1:0] height_r;
  logic [RW-1:0]                  row_count_r, row_count_nxt;
  logic [COL_W-1:0]               col_count_r, col_count_nxt;

  logic [WCW-1:0]   wx, eff_w;
  logic [RW-1:0]    eff_h;
  logic [RW-1:0]    row_cur, cr;
  logic [COL_W-1:0] col_cur, cc;
  logic             col_wrap, row_wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cfar_pkg::WIDTH_RST;
      height_r <= cfar_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        cfar_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[cfar_pkg::CFG_WID_W-1:0];
        cfar_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata[cfar_pkg::CFG_HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wx = WCW'(width_r);
    if (wx < WCW'(cfar_pkg::MIN_DIM)) begin
      eff_w = WCW'(cfar_pkg::MIN_DIM);
    end else if (wx > WCW'(MAX_WIDTH)) begin
      eff_w = WCW'(MAX_WIDTH);
    end else begin
      eff_w = wx;
    end
    eff_h = (height_r < RW'(cfar_pkg::MIN_DIM)) ? RW'(cfar_pkg::MIN_DIM) : height_r;
  end

  // A frame start forces the pixel to row 0, column 0.
  assign row_cur = frame_start ? '0 : row_count_r;
  assign col_cur = frame_start ? '0 : col_count_r;
  assign rd_col  = col_cur;

  assign cr = row_cur - RW'(cfar_pkg::WIN_LAG);
  assign cc = col_cur - COL_W'(cfar_pkg::WIN_LAG);

  always_comb begin
    pos.row  = cr;
    pos.col  = cfar_pkg::OUT_COL_W'(cc);
    pos.emit = (row_cur >= RW'(cfar_pkg::WIN_LAG)) && (col_cur >= COL_W'(cfar_pkg::WIN_LAG));
    pos.inb  = (cr >= RW'(cfar_pkg::BORDER)) &&
               (({1'b0, cr} + (RW+1)'(cfar_pkg::BORDER)) < {1'b0, eff_h}) &&
               (WCW'(cc) >= WCW'(cfar_pkg::BORDER)) &&
               ((WCX'(cc) + WCX'(cfar_pkg::BORDER)) < {1'b0, eff_w});
  end

  always_comb begin
    col_wrap      = (WCW'(col_cur) + WCW'(1)) >= eff_w;
    row_wrap      = ({1'b0, row_cur} + (RW+1)'(1)) >= {1'b0, eff_h};
    col_count_nxt = col_wrap ? '0 : col_cur + COL_W'(1);
    if (!col_wrap) begin
      row_count_nxt = row_cur;
    end else if (row_wrap) begin
      row_count_nxt = '0;
    end else begin
      row_count_nxt = row_cur + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
    end else if (accept) begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

endmodule

>>> design/cfar_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CA-CFAR line store
// One word per column holds the six previous rows of that column. Registered
// read with forwarding of a write to the same column in the same cycle.
// ----------------------------------------------------------------------------
module cfar_line_store #(
  parameter int MAX_WIDTH = cfar_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
  input  logic                               wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
  input  logic [cfar_pkg::COL_DATA_W-1:0]    wr_data,
  output logic [cfar_pkg::COL_DATA_W-1:0]    rd_data
);

  logic [cfar_pkg::COL_DATA_W-1:0] mem [MAX_WIDTH];
  logic [cfar_pkg::COL_DATA_W-1:0] rd_r;
  logic [cfar_pkg::COL_DATA_W-1:0] fwd_data_r;
  logic                            fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r       <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // The memory returns the old word when a column is written and read in the
  // same cycle, so the new word is taken from the write side instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_r;

endmodule

>>> design/cfar_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CA-CFAR window
// Keeps the 7x7 window as per-column sums: full seven-cell sums, outer
// four-cell sums and the middle-row pixels, shifted one column per pixel.
// ----------------------------------------------------------------------------
module cfar_window (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic [cfar_pkg::COL_DATA_W-1:0]    col_data,
  input  logic [cfar_pkg::PIX_W-1:0]         px,
  output cfar_pkg::cfar_sums_t               sums
);

  localparam int PW = cfar_pkg::PIX_W;
  localparam int FW = cfar_pkg::FULL_W;
  localparam int OW = cfar_pkg::OUTER_W;
  localparam int SW = cfar_pkg::SUM_W;

  // Indexed by window column; 6 is the newest column.
  logic [FW-1:0] full_r  [1:6];
  logic [OW-1:0] outer_r [3:6];
  logic [PW-1:0] mid_r   [4:6];

  logic [PW-1:0] v [0:6];
  logic [FW-1:0] full_in;
  logic [OW-1:0] outer_in;

  always_comb begin
    for (int r = 0; r < cfar_pkg::STORE_ROWS; r++) begin
      v[r] = col_data[r*PW +: PW];
    end
    v[6] = px;
    full_in  = FW'(v[0]) + FW'(v[1]) + FW'(v[2]) + FW'(v[3]) +
               FW'(v[4]) + FW'(v[5]) + FW'(v[6]);
    outer_in = OW'(v[0]) + OW'(v[1]) + OW'(v[5]) + OW'(v[6]);
  end

  // Training sum after the shift: full columns 0, 1, 5, 6 and the outer
  // cells of columns 2 to 4. Only the newest column's sum is left for later.
  always_comb begin
    sums.center   = mid_r[4];
    sums.part_a   = SW'(full_r[1]) + SW'(full_r[2]) + SW'(full_r[6]) +
                    SW'(outer_r[3]) + SW'(outer_r[4]) + SW'(outer_r[5]);
    sums.full_new = full_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 1; c <= 6; c++) full_r[c] <= '0;
      for (int c = 3; c <= 6; c++) outer_r[c] <= '0;
      for (int c = 4; c <= 6; c++) mid_r[c] <= '0;
    end else if (step) begin
      for (int c = 1; c < 6; c++) full_r[c] <= full_r[c+1];
      for (int c = 3; c < 6; c++) outer_r[c] <= outer_r[c+1];
      for (int c = 4; c < 6; c++) mid_r[c] <= mid_r[c+1];
      full_r[6]  <= full_in;
      outer_r[6] <= outer_in;
      mid_r[6]   <= v[3];
    end
  end

endmodule

>>> design/image_ca_cfar_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image CA-CFAR detector
// Raster-order pixel stream in, one target decision per centre pixel out.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_pixel_value, in_frame_start
//   out_     output     out_valid/out_stall out_row, out_col, out_is_target
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// One pixel is accepted per clock while in_stall is low; a decision passes the
// line store read, window sums and compare stages after its newest pixel is accepted.
// The line store has one read and one write port and sets the one-per-clock
// figure. It needs no clearing after reset, so pixels are taken at once.
// A stall on the output backs up through the three stages to in_stall.
// ----------------------------------------------------------------------------
module image_ca_cfar_detector #(
  parameter int MAX_WIDTH = cfar_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cfar_pkg::PIX_W-1:0]         in_pixel_value,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cfar_pkg::ROW_W-1:0]         out_row,
  output logic [cfar_pkg::OUT_COL_W-1:0]     out_col,
  output logic                               out_is_target,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cfar_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfar_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SW    = cfar_pkg::SUM_W;

  logic                in_acc;
  logic                out_free, s2_free, s1_go, s2_go;
  logic [COL_W-1:0]    rd_col;
  cfar_pkg::cfar_pos_t pos;

  logic                          s1_valid_r;
  cfar_pkg::cfar_pos_t           s1_pos_r;
  logic [COL_W-1:0]              s1_col_r;
  logic [cfar_pkg::PIX_W-1:0]    s1_px_r;
  logic [cfar_pkg::COL_DATA_W-1:0] col_data, wr_data;
  cfar_pkg::cfar_sums_t          sums;

  logic                          s2_valid_r;
  cfar_pkg::cfar_pos_t           s2_pos_r;
  cfar_pkg::cfar_sums_t          s2_sums_r;

  logic                          out_valid_r;
  logic [cfar_pkg::ROW_W-1:0]    out_row_r;
  logic [cfar_pkg::OUT_COL_W-1:0] out_col_r;
  logic                          out_tgt_r;
  logic [SW-1:0]                 train_sum, scaled_px;
  logic                          target_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_free  = !s2_valid_r || out_free;
  assign s2_go    = s2_valid_r && out_free;
  assign s1_go    = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  cfar_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .accept      (in_acc),
    .frame_start (in_frame_start),
    .rd_col      (rd_col),
    .pos         (pos)
  );

  // Each column word moves up one row; the new pixel becomes the newest row.
  assign wr_data = {s1_px_r, col_data[cfar_pkg::COL_DATA_W-1:cfar_pkg::PIX_W]};

  cfar_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (rd_col),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data (wr_data),
    .rd_data (col_data)
  );

  cfar_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_go),
    .col_data (col_data),
    .px       (s1_px_r),
    .sums     (sums)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos_r <= pos;
      s1_col_r <= rd_col;
      s1_px_r  <= in_pixel_value;
    end
  end

  // Only transactions that decide a centre pixel go on to the second stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_go) begin
      s2_valid_r <= s1_pos_r.emit;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_pos_r  <= s1_pos_r;
      s2_sums_r <= sums;
    end
  end

  // 40 * p is (p << 5) + (p << 3).
  always_comb begin
    train_sum  = s2_sums_r.part_a + SW'(s2_sums_r.full_new);
    scaled_px  = (SW'(s2_sums_r.center) << 5) + (SW'(s2_sums_r.center) << 3);
    target_nxt = s2_pos_r.inb && (scaled_px > train_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_row_r <= s2_pos_r.row;
      out_col_r <= s2_pos_r.col;
      out_tgt_r <= target_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_is_target = out_tgt_r;

endmodule
